// ----- rtl/msort_pkg.sv -----
// Shared constants and control/status types for the merge sort engine.
`timescale 1ns / 1ps

package msort_pkg;

  localparam int unsigned MaxItems   = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IdxW       = $clog2(MaxItems);
  localparam int unsigned CntW       = $clog2(MaxItems + 1);
  localparam int unsigned SumW       = CntW + 1;

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [CntW-1:0]       cnt_t;
  typedef logic [SumW-1:0]       sum_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the input beat (or flag overflow when full)
    logic sort_init;   // width 1, first run, primary buffer is source
    logic run_start;   // latch run bounds and fetch the two run heads
    logic merge_step;  // move one value into the destination buffer
    logic run_next;    // advance to the next pair of runs
    logic pass_next;   // double the run width and swap buffers
    logic emit_init;   // fetch the first sorted value
    logic emit_adv;    // fetch the next sorted value
    logic clear_set;   // drop the count and overflow flag
  } msort_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sort_done;   // run width covers the whole set
    logic runs_done;   // no runs left in this pass
    logic run_last;    // current merge step writes the last value of the run
    logic emit_last;   // value on the output is the final one of the set
  } msort_status_t;

endpackage

// ----- rtl/msort_if.sv -----
// Valid/ready stream interfaces for the input and result channels.
`timescale 1ns / 1ps

interface msort_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [msort_pkg::ValueWidth-1:0] element_value;
  logic                                is_last;

  modport source (output valid, output element_value, output is_last, input ready);
  modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

interface msort_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [msort_pkg::ValueWidth-1:0] sorted_value;
  logic                                last_result;
  logic                                overflowed;

  modport source (output valid, output sorted_value, output last_result,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflowed, output ready);
endinterface

// ----- rtl/msort_ctrl.sv -----
// Sequencer for loading, merge passes and emission of the sorted set.
`timescale 1ns / 1ps

module msort_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_last_i,
  input  logic                     out_ready_i,
  input  msort_pkg::msort_status_t status_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output msort_pkg::msort_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_PASS  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_MERGE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.sort_init = 1'b1;
            state_d         = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (status_i.sort_done) begin
          cmd_o.emit_init = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.runs_done) begin
          cmd_o.pass_next = 1'b1;
          state_d         = ST_PASS;
        end else begin
          cmd_o.run_start = 1'b1;
          state_d         = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd_o.merge_step = 1'b1;
        if (status_i.run_last) begin
          cmd_o.run_next = 1'b1;
          state_d        = ST_RUN;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.emit_last) begin
            cmd_o.clear_set = 1'b1;
            state_d         = ST_LOAD;
          end else begin
            cmd_o.emit_adv = 1'b1;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/msort_dp.sv -----
// Datapath: two value buffers, run pointers and the merge comparator.
`timescale 1ns / 1ps

module msort_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  msort_pkg::msort_cmd_t    cmd_i,
  input  msort_pkg::value_t        in_value_i,
  output msort_pkg::msort_status_t status_o,
  output msort_pkg::value_t        out_value_o,
  output logic                     out_ovf_o
);

  localparam int unsigned Depth = msort_pkg::MaxItems;
  localparam int unsigned CntW  = msort_pkg::CntW;
  localparam int unsigned IdxW  = msort_pkg::IdxW;
  localparam int unsigned SumW  = msort_pkg::SumW;

  msort_pkg::value_t mem0 [Depth];
  msort_pkg::value_t mem1 [Depth];
  msort_pkg::value_t m0_ra_q, m0_rb_q, m1_ra_q, m1_rb_q;

  msort_pkg::cnt_t count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            parity_q, parity_d;
  msort_pkg::sum_t w_q, w_d, lo_q, lo_d;
  msort_pkg::cnt_t a_q, a_d, b_q, b_d, k_q, k_d, mid_q, mid_d, hi_q, hi_d;
  msort_pkg::idx_t e_q, e_d;

  msort_pkg::idx_t   addr_a, addr_b, waddr;
  msort_pkg::value_t wdata, src_a, src_b;
  msort_pkg::sum_t   lo_w, lo_2w, n_ext;
  msort_pkg::cnt_t   mid_c, hi_c, cnt_m1;
  logic              full, a_live, b_live, take_a, m0_we, m1_we;

  assign full  = (count_q == CntW'(Depth));
  assign n_ext = SumW'(count_q);
  assign lo_w  = lo_q + w_q;
  assign lo_2w = lo_q + (w_q << 1);
  assign mid_c = (lo_w > n_ext)  ? count_q : lo_w[CntW-1:0];
  assign hi_c  = (lo_2w > n_ext) ? count_q : lo_2w[CntW-1:0];

  assign src_a = parity_q ? m1_ra_q : m0_ra_q;
  assign src_b = parity_q ? m1_rb_q : m0_rb_q;

  // Left run wins ties.
  assign a_live = (a_q < mid_q);
  assign b_live = (b_q < hi_q);
  assign take_a = a_live && (!b_live || ($signed(src_a) <= $signed(src_b)));

  assign cnt_m1 = count_q - CntW'(1);

  always_comb begin
    count_d  = count_q;
    ovf_d    = ovf_q;
    parity_d = parity_q;
    w_d      = w_q;
    lo_d     = lo_q;
    a_d      = a_q;
    b_d      = b_q;
    k_d      = k_q;
    mid_d    = mid_q;
    hi_d     = hi_q;
    e_d      = e_q;
    addr_a   = e_q;
    addr_b   = b_q[IdxW-1:0];

    if (cmd_i.load) begin
      if (full) ovf_d = 1'b1;
      else      count_d = count_q + CntW'(1);
    end
    if (cmd_i.sort_init) begin
      w_d      = SumW'(1);
      lo_d     = '0;
      parity_d = 1'b0;
    end
    if (cmd_i.run_start) begin
      a_d    = lo_q[CntW-1:0];
      b_d    = mid_c;
      k_d    = lo_q[CntW-1:0];
      mid_d  = mid_c;
      hi_d   = hi_c;
      addr_a = lo_q[IdxW-1:0];
      addr_b = mid_c[IdxW-1:0];
    end
    if (cmd_i.merge_step) begin
      a_d    = a_q + CntW'(take_a);
      b_d    = b_q + CntW'(!take_a);
      k_d    = k_q + CntW'(1);
      addr_a = a_d[IdxW-1:0];
      addr_b = b_d[IdxW-1:0];
    end
    if (cmd_i.run_next) begin
      lo_d = lo_2w;
    end
    if (cmd_i.pass_next) begin
      w_d      = w_q << 1;
      lo_d     = '0;
      parity_d = !parity_q;
    end
    if (cmd_i.emit_init) begin
      e_d    = '0;
      addr_a = '0;
    end
    if (cmd_i.emit_adv) begin
      e_d    = e_q + IdxW'(1);
      addr_a = e_d;
    end
    if (cmd_i.clear_set) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  // Load writes the primary buffer; a merge writes whichever buffer is not the source.
  assign m0_we = (cmd_i.load && !full) || (cmd_i.merge_step && parity_q);
  assign m1_we = cmd_i.merge_step && !parity_q;
  assign waddr = cmd_i.load ? count_q[IdxW-1:0] : k_q[IdxW-1:0];
  assign wdata = cmd_i.load ? in_value_i : (take_a ? src_a : src_b);

  always_ff @(posedge clk_i) begin
    if (m0_we) mem0[waddr] <= wdata;
    m0_ra_q <= mem0[addr_a];
    m0_rb_q <= mem0[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (m1_we) mem1[waddr] <= wdata;
    m1_ra_q <= mem1[addr_a];
    m1_rb_q <= mem1[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      parity_q <= 1'b0;
      w_q      <= SumW'(1);
      lo_q     <= '0;
      a_q      <= '0;
      b_q      <= '0;
      k_q      <= '0;
      mid_q    <= '0;
      hi_q     <= '0;
      e_q      <= '0;
    end else begin
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      parity_q <= parity_d;
      w_q      <= w_d;
      lo_q     <= lo_d;
      a_q      <= a_d;
      b_q      <= b_d;
      k_q      <= k_d;
      mid_q    <= mid_d;
      hi_q     <= hi_d;
      e_q      <= e_d;
    end
  end

  assign status_o.sort_done = (w_q >= n_ext);
  assign status_o.runs_done = (lo_q >= n_ext);
  assign status_o.run_last  = ((k_q + CntW'(1)) == hi_q);
  assign status_o.emit_last = (CntW'(e_q) == cnt_m1);

  assign out_value_o = src_a;
  assign out_ovf_o   = ovf_q;

endmodule

// ----- rtl/merge_sort_engine_unit.sv -----
// Top level of the merge sort engine: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
//   in_i  : one beat per signed value; is_last closes the set and starts the sort.
//   out_o : the stored values in ascending order, one beat each; last_result marks
//           the final beat, overflowed is set on every beat of a set that lost
//           values because more than MaxItems arrived.
// Equal values keep their arrival order.
// Sort passes and throughput:
//   Loading stores each beat as it arrives, up to MaxItems. After the closing
//   beat the engine runs ceil(log2 n) bottom-up merge passes over the n stored
//   values; each pass sets up each pair of runs in turn, moves one value per
//   cycle through the shared comparator (both run heads are read from the
//   source buffer through its two read ports every cycle), and then closes
//   the pass. The result beats then follow, one per cycle while the receiver
//   is ready.
// While sorting or emitting, in_i.ready stays low; the next set is taken only
// after the final result beat has been accepted.
// Reset (rst_ni low, asynchronous) empties the set and clears the overflow flag;
// buffer contents are not cleared, and no stale entry is used before being written.
// A stalled receiver holds the current result beat; the engine simply waits.

module merge_sort_engine_unit (
  input  logic clk_i,
  input  logic rst_ni,
  msort_in_if.sink    in_i,
  msort_out_if.source out_o
);

  msort_pkg::msort_cmd_t    cmd;
  msort_pkg::msort_status_t status;
  msort_pkg::value_t        out_value;
  logic                     out_ovf;

  // Sequence load, merge passes and emission.
  msort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.is_last),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // Hold the buffers, pointers and comparator.
  msort_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_value_i  (in_i.element_value),
    .status_o    (status),
    .out_value_o (out_value),
    .out_ovf_o   (out_ovf)
  );

  assign out_o.sorted_value = out_value;
  assign out_o.last_result  = status.emit_last;
  assign out_o.overflowed   = out_ovf;

endmodule

// ----- rtl/msort_checker.sv -----
// Port-level assertions for the merge sort engine, bound to the top level.
`timescale 1ns / 1ps

module msort_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_last_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [msort_pkg::ValueWidth-1:0] sorted_value_i,
  input logic                          last_result_i,
  input logic                          overflowed_i
);

  msort_pkg::value_t prev_q;
  logic              prev_vld_q, ovf_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_vld_q <= 1'b0;
      ovf_prev_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      prev_vld_q <= !last_result_i;
      ovf_prev_q <= overflowed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_i && out_ready_i) prev_q <= sorted_value_i;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sorted_value_i))
    else $error("result beat dropped or changed while stalled");

  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken while results are being delivered");

  a_stop_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input still open after closing beat");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prev_vld_q |-> $signed(sorted_value_i) >= $signed(prev_q))
    else $error("results not in ascending order");

  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prev_vld_q |-> overflowed_i == ovf_prev_q)
    else $error("overflow flag changed within a set");

endmodule

bind merge_sort_engine_unit msort_checker u_msort_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_last_i      (in_i.is_last),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .sorted_value_i (out_o.sorted_value),
  .last_result_i  (out_o.last_result),
  .overflowed_i   (out_o.overflowed)
);
